@@ rtl/splr_pkg.sv @@
package splr_pkg;

  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int PALETTE_SIZE    = 16;
  localparam int ENTRY_W         = 4;
  localparam logic [ENTRY_W-1:0] INDEX_MASK = 4'hF;

  localparam int KIND_W    = 2;
  localparam int PIX_W     = 8;
  localparam int LINE_W    = 8;
  localparam int COLOR_W   = 32;
  localparam int S_TDATA_W = 56;

  localparam int FW_W       = 11;
  localparam int FH_W       = 9;
  localparam int VP_W       = 9;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FW_W-1:0] FW_RESET = 11'd320;
  localparam logic [FH_W-1:0] FH_RESET = 9'd200;
  localparam logic [VP_W-1:0] VP_RESET = 9'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_ROWS = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_LINE_WR = 2'd1,
    KIND_BASE_WR = 2'd2
  } kind_e;

  typedef struct packed {
    logic line_we;
    logic base_we;
    logic rd_en;
    logic rd_line;
  } mem_ctl_t;

endpackage

@@ rtl/scanline_palette_pixel_resolver.sv @@
// A pixel transfer is read from the palette RAM into stage 1, then registered onto m_axis.
// Throughput: one item per cycle unless m_axis stalls.
// The palette RAM has one write and one read port; palette loads give no result.
// Reset clears the row and column counters, the pipeline valids and restores the
// size registers to 320 x 200 with no viewport; palette contents are not cleared.
module scanline_palette_pixel_resolver #(
  parameter int MAX_ROWS    = splr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = splr_pkg::DEF_MAX_COLUMNS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [splr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [splr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_index[7:0], palette_line[15:8], palette_entry[19:16], entry_color[51:20]
  input  logic [splr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [splr_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // argb[31:0]
  output logic [splr_pkg::COLOR_W-1:0]     m_axis_tdata,
  output logic                             m_axis_tlast,
  // end_of_frame[0]
  output logic [0:0]                       m_axis_tuser
);
  import splr_pkg::*;

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNTW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WCW  = ($clog2(MAX_COLUMNS + 1) > FW_W) ? $clog2(MAX_COLUMNS + 1) : FW_W;
  localparam int HCW  = ($clog2(MAX_ROWS + 1) > FH_W) ? $clog2(MAX_ROWS + 1) : FH_W;

  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [VP_W-1:0] viewport_rows_q;

  logic [CNTW-1:0] col_q, col_d;
  logic [RW-1:0]   row_q, row_d;

  logic s1_valid_q, s1_eor_q, s1_eof_q;
  logic out_valid_q, out_eor_q, out_eof_q;
  logic [COLOR_W-1:0] out_argb_q;
  logic [COLOR_W-1:0] rdata;

  kind_e               kind;
  logic [PIX_W-1:0]    pix;
  logic [LINE_W-1:0]   pal_line;
  logic [ENTRY_W-1:0]  pal_entry;
  logic [COLOR_W-1:0]  color;

  logic s_xfer, pix_xfer, out_ld;
  logic [WCW-1:0] fw_ext, w_eff, col_next;
  logic [HCW-1:0] fh_ext, h_eff, row_ext, row_next, vp_ext, line_ext;
  logic eor, eof, use_line, line_ok;
  mem_ctl_t mem_ctl;

  assign kind      = kind_e'(s_axis_tuser);
  assign pix       = s_axis_tdata[7:0];
  assign pal_line  = s_axis_tdata[15:8];
  assign pal_entry = s_axis_tdata[19:16];
  assign color     = s_axis_tdata[51:20];

  assign cfg_ready_o   = 1'b1;
  assign out_ld        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_ld;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign pix_xfer      = s_xfer && (kind == KIND_PIXEL);

  always_comb begin
    fw_ext = WCW'(frame_width_q);
    if (fw_ext == '0) begin
      w_eff = WCW'(1);
    end else if (fw_ext > WCW'(MAX_COLUMNS)) begin
      w_eff = WCW'(MAX_COLUMNS);
    end else begin
      w_eff = fw_ext;
    end
    fh_ext = HCW'(frame_height_q);
    if (fh_ext == '0) begin
      h_eff = HCW'(1);
    end else if (fh_ext > HCW'(MAX_ROWS)) begin
      h_eff = HCW'(MAX_ROWS);
    end else begin
      h_eff = fh_ext;
    end
    col_next = WCW'(col_q) + WCW'(1);
    row_ext  = HCW'(row_q);
    row_next = row_ext + HCW'(1);
    vp_ext   = HCW'(viewport_rows_q);
    line_ext = HCW'(pal_line);
    eor      = col_next >= w_eff;
    eof      = eor && (row_next >= h_eff);
    use_line = (row_ext < vp_ext) && (row_ext < h_eff) && (row_ext < HCW'(MAX_ROWS));
    line_ok  = line_ext < HCW'(MAX_ROWS);
    if (eor) begin
      col_d = '0;
      row_d = eof ? '0 : row_next[RW-1:0];
    end else begin
      col_d = col_next[CNTW-1:0];
      row_d = row_q;
    end
  end

  always_comb begin
    mem_ctl.line_we = 1'b0;
    mem_ctl.base_we = 1'b0;
    mem_ctl.rd_en   = pix_xfer;
    mem_ctl.rd_line = use_line;
    if (s_xfer) begin
      unique case (kind)
        KIND_PIXEL:   ;
        KIND_LINE_WR: mem_ctl.line_we = line_ok;
        KIND_BASE_WR: mem_ctl.base_we = 1'b1;
        default:      ;
      endcase
    end
  end

  splr_palette_store #(
    .MAX_ROWS (MAX_ROWS)
  ) u_store (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .wrow_i   (line_ext[RW-1:0]),
    .wentry_i (pal_entry),
    .wdata_i  (color),
    .rrow_i   (row_q),
    .rsel_i   (pix[ENTRY_W-1:0] & INDEX_MASK),
    .rdata_o  (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= FW_RESET;
      frame_height_q  <= FH_RESET;
      viewport_rows_q <= VP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[FH_W-1:0];
        CFG_VIEWPORT_ROWS: viewport_rows_q <= cfg_data_i[VP_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pix_xfer) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s_xfer) begin
        s1_valid_q <= (kind == KIND_PIXEL);
      end else if (out_ld) begin
        s1_valid_q <= 1'b0;
      end
      if (out_ld) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      s1_eor_q <= eor;
      s1_eof_q <= eof;
    end
    if (out_ld && s1_valid_q) begin
      out_argb_q <= rdata;
      out_eor_q  <= s1_eor_q;
      out_eof_q  <= s1_eof_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_argb_q;
  assign m_axis_tlast    = out_eor_q;
  assign m_axis_tuser[0] = out_eof_q;

  a_eof_has_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_eof_q |-> out_eor_q)
    else $error("end of frame without end of row");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WCW'(col_q) < WCW'(MAX_COLUMNS))
    else $error("column counter out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HCW'(row_q) < HCW'(MAX_ROWS))
    else $error("row counter out of range");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer && eor |=> col_q == '0)
    else $error("column counter did not wrap at end of row");

endmodule

@@ rtl/splr_palette_store.sv @@
module splr_palette_store #(
  parameter int MAX_ROWS = splr_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk_i,
  input  splr_pkg::mem_ctl_t             ctl_i,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wrow_i,
  input  logic [splr_pkg::ENTRY_W-1:0]   wentry_i,
  input  logic [splr_pkg::COLOR_W-1:0]   wdata_i,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rrow_i,
  input  logic [splr_pkg::ENTRY_W-1:0]   rsel_i,
  output logic [splr_pkg::COLOR_W-1:0]   rdata_o
);
  import splr_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_ROWS * PALETTE_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [COLOR_W-1:0] line_mem [DEPTH];
  logic [COLOR_W-1:0] base_mem [PALETTE_SIZE];
  logic [COLOR_W-1:0] line_rd_q;
  logic [COLOR_W-1:0] base_rd_q;
  logic               rd_line_q;
  logic [RW+ENTRY_W-1:0] waddr_full;
  logic [RW+ENTRY_W-1:0] raddr_full;

  assign waddr_full = {wrow_i, wentry_i};
  assign raddr_full = {rrow_i, rsel_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.line_we) begin
      line_mem[waddr_full[AW-1:0]] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      line_rd_q <= line_mem[raddr_full[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.base_we) begin
      base_mem[wentry_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      base_rd_q <= base_mem[rsel_i];
      rd_line_q <= ctl_i.rd_line;
    end
  end

  assign rdata_o = rd_line_q ? line_rd_q : base_rd_q;

endmodule
